// ----- rtl/bracket_loop_byte_tape_machine_macros.svh -----
// Assertion macros shared by the checker of the byte-tape machine.
// Each macro expects clock and reset in scope; no other dependencies.
`ifndef BRACKET_LOOP_BYTE_TAPE_MACHINE_MACROS_SVH
`define BRACKET_LOOP_BYTE_TAPE_MACHINE_MACROS_SVH

// same-cycle implication
`define BLT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define BLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/blt_pkg.sv -----
// Package of the byte-tape machine: field widths, codes, microcode types and ROM.
// No dependencies; used by blt_seq, the top level and the checker.
`timescale 1ns / 1ps

package blt_pkg;

   localparam int KIND_W     = 2;
   localparam int ADDR_W     = 12;
   localparam int OP_W       = 3;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 13;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (BYTE_W + 4 + LEN_W);

   localparam int RSP_OVALID_BIT = BYTE_W;
   localparam int RSP_TAKEN_BIT  = BYTE_W + 1;
   localparam int RSP_HALT_BIT   = BYTE_W + 2;
   localparam int RSP_ERR_BIT    = BYTE_W + 3;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STEP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   localparam logic [OP_W-1:0] OP_PTR_INC  = 3'd0;
   localparam logic [OP_W-1:0] OP_PTR_DEC  = 3'd1;
   localparam logic [OP_W-1:0] OP_CELL_INC = 3'd2;
   localparam logic [OP_W-1:0] OP_CELL_DEC = 3'd3;
   localparam logic [OP_W-1:0] OP_OUT      = 3'd4;
   localparam logic [OP_W-1:0] OP_IN       = 3'd5;
   localparam logic [OP_W-1:0] OP_OPEN     = 3'd6;
   localparam logic [OP_W-1:0] OP_CLOSE    = 3'd7;

   localparam int UPC_W = 4;

   localparam logic [UPC_W-1:0] U_IDLE    = 4'd0;
   localparam logic [UPC_W-1:0] U_LOAD    = 4'd1;
   localparam logic [UPC_W-1:0] U_FETCH   = 4'd2;
   localparam logic [UPC_W-1:0] U_EXEC    = 4'd3;
   localparam logic [UPC_W-1:0] U_RD_FWD  = 4'd4;
   localparam logic [UPC_W-1:0] U_TST_FWD = 4'd5;
   localparam logic [UPC_W-1:0] U_RD_BWD  = 4'd6;
   localparam logic [UPC_W-1:0] U_TST_BWD = 4'd7;
   localparam logic [UPC_W-1:0] U_CLR     = 4'd8;
   localparam logic [UPC_W-1:0] U_BOOT    = 4'd9;
   localparam logic [UPC_W-1:0] U_RESP    = 4'd10;

   typedef enum logic [3:0] {
      A_WAIT,
      A_LOAD,
      A_FETCH,
      A_EXEC,
      A_RD_FWD,
      A_TST_FWD,
      A_RD_BWD,
      A_TST_BWD,
      A_CLEAR,
      A_RESPOND
   } act_type;

   typedef enum logic [2:0] {
      J_GOTO,
      J_DISPATCH,
      J_HALTED,
      J_BRACKET,
      J_SCAN_END,
      J_LOOP,
      J_CLR_DONE,
      J_RSP
   } jmp_type;

   typedef struct packed {
      act_type          act;
      jmp_type          jmp;
      logic [UPC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic              accept;
      logic [KIND_W-1:0] kind;
      logic              halted;
      logic              clr_done;
      logic              scan_fwd;
      logic              scan_bwd;
      logic              scan_end;
      logic              match;
      logic              rsp_free;
   } status_type;

   function automatic ctrl_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctrl_type w;
      unique case (upc)
         U_IDLE:    w = '{A_WAIT,    J_DISPATCH, U_IDLE};
         U_LOAD:    w = '{A_LOAD,    J_GOTO,     U_RESP};
         U_FETCH:   w = '{A_FETCH,   J_HALTED,   U_RESP};
         U_EXEC:    w = '{A_EXEC,    J_BRACKET,  U_RESP};
         U_RD_FWD:  w = '{A_RD_FWD,  J_SCAN_END, U_RESP};
         U_TST_FWD: w = '{A_TST_FWD, J_LOOP,     U_RESP};
         U_RD_BWD:  w = '{A_RD_BWD,  J_SCAN_END, U_RESP};
         U_TST_BWD: w = '{A_TST_BWD, J_LOOP,     U_RESP};
         U_CLR:     w = '{A_CLEAR,   J_CLR_DONE, U_RESP};
         U_BOOT:    w = '{A_CLEAR,   J_CLR_DONE, U_IDLE};
         U_RESP:    w = '{A_RESPOND, J_RSP,      U_IDLE};
         default:   w = '{A_WAIT,    J_GOTO,     U_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/blt_seq.sv -----
// Microcode sequencer of the byte-tape machine: step counter, control ROM, jumps.
// Depends on blt_pkg.
`timescale 1ns / 1ps

module blt_seq import blt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type stat,
   output ctrl_type   ctrl
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;

   always_comb begin
      ctrl = ucode_rom(upc_ff);
   end

   always_comb begin
      upc_in = upc_ff;
      unique case (ctrl.jmp)
         J_GOTO: begin
            upc_in = ctrl.target;
         end
         J_DISPATCH: begin
            if (stat.accept) begin
               unique case (stat.kind)
                  KIND_LOAD:    upc_in = U_LOAD;
                  KIND_STEP:    upc_in = U_FETCH;
                  KIND_RESTART: upc_in = U_CLR;
                  default:      upc_in = U_RESP;
               endcase
            end
         end
         J_HALTED: begin
            upc_in = stat.halted ? ctrl.target : upc_ff + UPC_W'(1);
         end
         J_BRACKET: begin
            if (stat.scan_fwd) begin
               upc_in = U_RD_FWD;
            end else if (stat.scan_bwd) begin
               upc_in = U_RD_BWD;
            end else begin
               upc_in = ctrl.target;
            end
         end
         J_SCAN_END: begin
            upc_in = stat.scan_end ? ctrl.target : upc_ff + UPC_W'(1);
         end
         J_LOOP: begin
            upc_in = stat.match ? ctrl.target : upc_ff - UPC_W'(1);
         end
         J_CLR_DONE: begin
            if (stat.clr_done) begin
               upc_in = ctrl.target;
            end
         end
         J_RSP: begin
            if (stat.rsp_free) begin
               upc_in = ctrl.target;
            end
         end
         default: begin
            upc_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_BOOT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- rtl/bracket_loop_byte_tape_machine.sv -----
// Top level of the byte-tape machine: datapath, program memory and tape.
// Depends on blt_pkg and blt_seq.
//
//   port group   dir   contents
//   req_*        in    tdata = address, opcode, in_byte; tuser = kind
//   rsp_*        out   tdata = out_byte .. program_counter, one per transaction
//   csr_*        in    program_length write
//
// Load: accept, program write, response; an ignored kind goes straight to the response.
// Step: fetch, execute, response, from fetch straight to response when halted; a bracket jump
// adds a read and test per entry scanned (one program read port), one more read if unmatched.
// Restart: clears the tape one cell per cycle, then responds.
// After reset a tape clear runs with req_tready low.
// A waiting response does not block the next accept; it stalls only the
// response step of the following transaction.
`timescale 1ns / 1ps

module bracket_loop_byte_tape_machine import blt_pkg::*; #(
   parameter int PROG_DEPTH = 4096,
   parameter int TAPE_CELLS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // address[11:0], opcode[14:12], in_byte[22:15]
   input  logic [KIND_W-1:0]     req_tuser,  // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_byte[7:0], out_valid[8], byte_taken[9],
                                             // halted[10], bracket_error[11],
                                             // program_counter[24:12]
   input  logic                  csr_wen,
   input  logic [LEN_W-1:0]      csr_wdata
);

   localparam int PA_W = $clog2(PROG_DEPTH);
   localparam int PC_W = $clog2(PROG_DEPTH + 1);
   localparam int DP_W = $clog2(TAPE_CELLS);
   localparam int CW   = (PC_W > LEN_W) ? PC_W : LEN_W;
   localparam int AXW  = (PA_W > ADDR_W) ? PA_W : ADDR_W;

   ctrl_type   ctrl;
   status_type stat;

   logic [OP_W-1:0]   prog_mem [PROG_DEPTH];
   logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];

   logic [LEN_W-1:0]  prog_len_ff;
   logic [ADDR_W-1:0] addr_ff,   addr_in;
   logic [OP_W-1:0]   iop_ff,    iop_in;
   logic [BYTE_W-1:0] ibyte_ff,  ibyte_in;
   logic [PC_W-1:0]   pc_ff,     pc_in;
   logic [DP_W-1:0]   dp_ff,     dp_in;
   logic              err_ff,    err_in;
   logic [PC_W-1:0]   scan_ff,   scan_in;
   logic [PC_W-1:0]   depth_ff,  depth_in;
   logic [DP_W-1:0]   clr_ff,    clr_in;
   logic [BYTE_W-1:0] ob_ff,     ob_in;
   logic              ov_ff,     ov_in;
   logic              bt_ff,     bt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [OP_W-1:0]   op_ff;
   logic [BYTE_W-1:0] cell_ff;

   logic              prog_we, prog_re, tape_we, tape_re;
   logic [PA_W-1:0]   prog_waddr, prog_raddr;
   logic [DP_W-1:0]   tape_waddr;
   logic [BYTE_W-1:0] tape_wdata;
   logic [CW-1:0]     len_x;
   logic [PC_W-1:0]   eff_len;
   logic [AXW-1:0]    addr_x;
   logic [PC_W-1:0]   scan_dec;
   logic [CW-1:0]     pc_x;
   logic              halted_now, accept, rsp_free;
   logic              scan_fwd, scan_bwd, scan_end, match;

   blt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign req_tready = (ctrl.act == A_WAIT);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign len_x      = CW'(prog_len_ff);
   assign eff_len    = (len_x > CW'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : len_x[PC_W-1:0];
   assign halted_now = err_ff || (pc_ff >= eff_len);
   assign addr_x     = AXW'(addr_ff);
   assign prog_waddr = addr_x[PA_W-1:0];
   assign scan_dec   = scan_ff - PC_W'(1);
   assign pc_x       = CW'(pc_ff);

   assign stat = '{
      accept:   accept,
      kind:     req_tuser,
      halted:   halted_now,
      clr_done: (clr_ff == DP_W'(TAPE_CELLS - 1)),
      scan_fwd: scan_fwd,
      scan_bwd: scan_bwd,
      scan_end: scan_end,
      match:    match,
      rsp_free: rsp_free
   };

   always_comb begin
      addr_in      = addr_ff;
      iop_in       = iop_ff;
      ibyte_in     = ibyte_ff;
      pc_in        = pc_ff;
      dp_in        = dp_ff;
      err_in       = err_ff;
      scan_in      = scan_ff;
      depth_in     = depth_ff;
      clr_in       = clr_ff;
      ob_in        = ob_ff;
      ov_in        = ov_ff;
      bt_in        = bt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      prog_we      = 1'b0;
      prog_re      = 1'b0;
      prog_raddr   = pc_ff[PA_W-1:0];
      tape_we      = 1'b0;
      tape_re      = 1'b0;
      tape_waddr   = dp_ff;
      tape_wdata   = cell_ff;
      scan_fwd     = 1'b0;
      scan_bwd     = 1'b0;
      scan_end     = 1'b0;
      match        = 1'b0;

      unique case (ctrl.act)
         A_WAIT: begin
            if (accept) begin
               addr_in  = req_tdata[ADDR_W-1:0];
               iop_in   = req_tdata[ADDR_W+OP_W-1:ADDR_W];
               ibyte_in = req_tdata[ADDR_W+OP_W+BYTE_W-1:ADDR_W+OP_W];
               ob_in    = '0;
               ov_in    = 1'b0;
               bt_in    = 1'b0;
            end
         end
         A_LOAD: begin
            prog_we = 1'b1;
         end
         A_FETCH: begin
            prog_re = !halted_now;
            tape_re = !halted_now;
         end
         A_EXEC: begin
            pc_in = pc_ff + PC_W'(1);
            unique case (op_ff)
               OP_PTR_INC: begin
                  dp_in = (dp_ff == DP_W'(TAPE_CELLS - 1)) ? '0 : dp_ff + DP_W'(1);
               end
               OP_PTR_DEC: begin
                  dp_in = (dp_ff == '0) ? DP_W'(TAPE_CELLS - 1) : dp_ff - DP_W'(1);
               end
               OP_CELL_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_ff + BYTE_W'(1);
               end
               OP_CELL_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_ff - BYTE_W'(1);
               end
               OP_OUT: begin
                  ob_in = cell_ff;
                  ov_in = 1'b1;
               end
               OP_IN: begin
                  tape_we    = 1'b1;
                  tape_wdata = ibyte_ff;
                  bt_in      = 1'b1;
               end
               OP_OPEN: begin
                  if (cell_ff == '0) begin
                     scan_fwd = 1'b1;
                     pc_in    = pc_ff;
                     scan_in  = pc_ff + PC_W'(1);
                     depth_in = '0;
                  end
               end
               OP_CLOSE: begin
                  if (cell_ff != '0) begin
                     scan_bwd = 1'b1;
                     pc_in    = pc_ff;
                     scan_in  = pc_ff;
                     depth_in = '0;
                  end
               end
            endcase
         end
         A_RD_FWD: begin
            if (scan_ff >= eff_len) begin
               scan_end = 1'b1;
               err_in   = 1'b1;
            end else begin
               prog_re    = 1'b1;
               prog_raddr = scan_ff[PA_W-1:0];
            end
         end
         A_TST_FWD: begin
            if (op_ff == OP_CLOSE && depth_ff == '0) begin
               match = 1'b1;
               pc_in = scan_ff + PC_W'(1);
            end else begin
               if (op_ff == OP_CLOSE) begin
                  depth_in = depth_ff - PC_W'(1);
               end else if (op_ff == OP_OPEN) begin
                  depth_in = depth_ff + PC_W'(1);
               end
               scan_in = scan_ff + PC_W'(1);
            end
         end
         A_RD_BWD: begin
            if (scan_ff == '0) begin
               scan_end = 1'b1;
               err_in   = 1'b1;
            end else begin
               prog_re    = 1'b1;
               prog_raddr = scan_dec[PA_W-1:0];
               scan_in    = scan_dec;
            end
         end
         A_TST_BWD: begin
            if (op_ff == OP_OPEN && depth_ff == '0) begin
               match = 1'b1;
               pc_in = scan_ff + PC_W'(1);
            end else if (op_ff == OP_OPEN) begin
               depth_in = depth_ff - PC_W'(1);
            end else if (op_ff == OP_CLOSE) begin
               depth_in = depth_ff + PC_W'(1);
            end
         end
         A_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            tape_wdata = '0;
            clr_in     = stat.clr_done ? '0 : clr_ff + DP_W'(1);
            pc_in      = '0;
            dp_in      = '0;
            err_in     = 1'b0;
         end
         A_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD_W'(0), pc_x[LEN_W-1:0], err_ff, halted_now,
                               bt_ff, ov_ff, ob_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_waddr] <= iop_ff;
      end
      if (prog_re) begin
         op_ff <= prog_mem[prog_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      if (tape_re) begin
         cell_ff <= tape_mem[dp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff  <= '0;
         pc_ff        <= '0;
         dp_ff        <= '0;
         err_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            prog_len_ff <= csr_wdata;
         end
         pc_ff        <= pc_in;
         dp_ff        <= dp_in;
         err_ff       <= err_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      iop_ff      <= iop_in;
      ibyte_ff    <= ibyte_in;
      scan_ff     <= scan_in;
      depth_ff    <= depth_in;
      ob_ff       <= ob_in;
      ov_ff       <= ov_in;
      bt_ff       <= bt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/blt_chk.sv -----
// Port-level checker of the byte-tape machine, bound to the top level.
// Depends on blt_pkg and bracket_loop_byte_tape_machine_macros.svh.
`timescale 1ns / 1ps
`include "bracket_loop_byte_tape_machine_macros.svh"

module blt_chk import blt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `BLT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BLT_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `BLT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `BLT_ASSERT_NOW(a_err_halts, rsp_tvalid && rsp_tdata[RSP_ERR_BIT], rsp_tdata[RSP_HALT_BIT])
   `BLT_ASSERT_NOW(a_out_in_excl, rsp_tvalid,
                   !(rsp_tdata[RSP_OVALID_BIT] && rsp_tdata[RSP_TAKEN_BIT]))

endmodule

bind bracket_loop_byte_tape_machine blt_chk u_blt_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/bracket_loop_byte_tape_machine_checker.sv -----
// Response checker for the byte-tape machine: mirrors program memory, tape and run
// state from the observed transactions and compares every response field by field.
// Depends on blt_pkg.
`timescale 1ns / 1ps

module bracket_loop_byte_tape_machine_checker import blt_pkg::*; #(
   parameter int PROG_DEPTH = 4096,
   parameter int TAPE_CELLS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // address[11:0], opcode[14:12], in_byte[22:15]
   input  logic [KIND_W-1:0]     req_tuser,  // kind[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // out_byte[7:0], out_valid[8], byte_taken[9],
                                             // halted[10], bracket_error[11],
                                             // program_counter[24:12]
   input  logic                  csr_wen,
   input  logic [LEN_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int PTR_W = $clog2(TAPE_CELLS);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              byte_taken;
      logic              halted;
      logic              bracket_error;
      logic [LEN_W-1:0]  program_counter;
   } tape_status_type;

   logic [OP_W-1:0]   program_mem [PROG_DEPTH];
   logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];
   logic [LEN_W-1:0]  pc_q;
   logic [LEN_W-1:0]  length_q;
   logic [PTR_W-1:0]  ptr_q;
   logic              err_q;
   tape_status_type   status_q [$];
   int                mismatch_count = 0;
   int                pending_count = 0;

   assign fail_count  = mismatch_count;
   assign outstanding = pending_count;

   initial begin
      for (int i = 0; i < PROG_DEPTH; i++) program_mem[i] = '0;
   end

   function automatic int run_length();
      return (length_q > PROG_DEPTH) ? PROG_DEPTH : int'(length_q);
   endfunction

   function automatic logic machine_halted();
      return err_q || (int'(pc_q) >= run_length());
   endfunction

   task automatic clear_tape();
      for (int i = 0; i < TAPE_CELLS; i++) tape_mem[i] = '0;
   endtask

   task automatic execute_instruction(input logic [BYTE_W-1:0] in_byte,
                                      inout tape_status_type st);
      int               len;
      int               idx;
      int               depth;
      int               nxt;
      logic             found;
      logic [OP_W-1:0]  op;
      logic [BYTE_W-1:0] cur_val;
      len     = run_length();
      op      = program_mem[pc_q];
      cur_val = tape_mem[ptr_q];
      nxt     = int'(pc_q) + 1;
      depth   = 0;
      found   = 1'b0;
      case (op)
         OP_PTR_INC:  ptr_q = PTR_W'((int'(ptr_q) + 1) % TAPE_CELLS);
         OP_PTR_DEC:  ptr_q = PTR_W'((int'(ptr_q) + TAPE_CELLS - 1) % TAPE_CELLS);
         OP_CELL_INC: tape_mem[ptr_q] = cur_val + 1'b1;
         OP_CELL_DEC: tape_mem[ptr_q] = cur_val - 1'b1;
         OP_OUT: begin
            st.out_byte  = cur_val;
            st.out_valid = 1'b1;
         end
         OP_IN: begin
            tape_mem[ptr_q] = in_byte;
            st.byte_taken   = 1'b1;
         end
         OP_OPEN: begin
            if (cur_val == '0) begin
               idx = int'(pc_q) + 1;
               while (!found && idx < len) begin
                  if (program_mem[idx] == OP_OPEN) depth++;
                  else if (program_mem[idx] == OP_CLOSE) begin
                     if (depth == 0) found = 1'b1;
                     else depth--;
                  end
                  if (!found) idx++;
               end
               if (found) nxt = idx + 1;
               else begin
                  err_q = 1'b1;
                  nxt   = int'(pc_q);
               end
            end
         end
         default: begin
            if (cur_val != '0) begin
               idx = int'(pc_q);
               while (!found && idx > 0) begin
                  idx--;
                  if (program_mem[idx] == OP_CLOSE) depth++;
                  else if (program_mem[idx] == OP_OPEN) begin
                     if (depth == 0) found = 1'b1;
                     else depth--;
                  end
               end
               if (found) nxt = idx + 1;
               else begin
                  err_q = 1'b1;
                  nxt   = int'(pc_q);
               end
            end
         end
      endcase
      pc_q = LEN_W'(nxt);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      tape_status_type want;
      tape_status_type got;
      if (reset) begin
         pc_q     = '0;
         ptr_q    = '0;
         err_q    = 1'b0;
         length_q = '0;
         clear_tape();
         status_q.delete();
         pending_count <= 0;
      end else begin
         if (csr_wen) length_q = csr_wdata;
         if (req_tvalid && req_tready) begin
            want = '0;
            case (req_tuser)
               KIND_LOAD:
                  program_mem[req_tdata[ADDR_W-1:0] % PROG_DEPTH] = req_tdata[ADDR_W +: OP_W];
               KIND_STEP:
                  if (!machine_halted())
                     execute_instruction(req_tdata[ADDR_W+OP_W +: BYTE_W], want);
               KIND_RESTART: begin
                  clear_tape();
                  pc_q  = '0;
                  ptr_q = '0;
                  err_q = 1'b0;
               end
               default: ;
            endcase
            want.halted          = machine_halted();
            want.bracket_error   = err_q;
            want.program_counter = pc_q;
            status_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte        = rsp_tdata[BYTE_W-1:0];
            got.out_valid       = rsp_tdata[RSP_OVALID_BIT];
            got.byte_taken      = rsp_tdata[RSP_TAKEN_BIT];
            got.halted          = rsp_tdata[RSP_HALT_BIT];
            got.bracket_error   = rsp_tdata[RSP_ERR_BIT];
            got.program_counter = rsp_tdata[RSP_ERR_BIT+1 +: LEN_W];
            if (status_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with no pending transaction, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = status_q.pop_front();
               compare_field("out_byte", want.out_byte, got.out_byte);
               compare_field("out_valid", want.out_valid, got.out_valid);
               compare_field("byte_taken", want.byte_taken, got.byte_taken);
               compare_field("halted", want.halted, got.halted);
               compare_field("bracket_error", want.bracket_error, got.bracket_error);
               compare_field("program_counter", want.program_counter, got.program_counter);
            end
         end
         pending_count <= status_q.size();
      end
   end

endmodule

// ----- test/tb_bracket_loop_byte_tape_machine.sv -----
// Testbench top for the byte-tape machine: clock, reset, stimulus, response
// back-pressure, watchdog and verdict. Depends on blt_pkg, the block and
// bracket_loop_byte_tape_machine_checker.
`timescale 1ns / 1ps

module tb_bracket_loop_byte_tape_machine;
   import blt_pkg::*;

   localparam int PROG_DEPTH   = 4096;
   localparam int TAPE_CELLS   = 4096;
   localparam int TOTAL_ITEMS  = 420;
   localparam int FILL_DEPTH   = 64;
   localparam int STALL_LIMIT  = 40000;
   localparam int LONG_HOLD    = 400;
   localparam int MAX_PROG     = 40;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [LEN_W-1:0]  LEN_MAX     = '1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // address[11:0], opcode[14:12], in_byte[22:15]
   logic [KIND_W-1:0]     req_tuser;  // kind[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // out_byte[7:0], out_valid[8], byte_taken[9],
                                      // halted[10], bracket_error[11], program_counter[24:12]
   logic                  csr_wen;
   logic [LEN_W-1:0]      csr_wdata;

   int              fail_count;
   int              outstanding;
   int              stall_cycles = 0;
   int              sent_count = 0;
   logic            burst = 1'b0;
   logic            hold_req = 1'b0;
   logic [OP_W-1:0] prog_buf [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bracket_loop_byte_tape_machine #(
      .PROG_DEPTH(PROG_DEPTH),
      .TAPE_CELLS(TAPE_CELLS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata)
   );

   bracket_loop_byte_tape_machine_checker #(
      .PROG_DEPTH(PROG_DEPTH),
      .TAPE_CELLS(TAPE_CELLS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_bracket_loop_byte_tape_machine failed");
            $finish;
         end
      end
   end

   // response side: random stalls, one long hold on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            gap      = LONG_HOLD;
         end else begin
            gap = burst ? 0 : $urandom_range(0, 16);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input int addr,
                            input int op, input int data);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, BYTE_W'(data), OP_W'(op), ADDR_W'(addr)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_length(input int len);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= LEN_W'(len);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic load_program();
      for (int k = 0; k < prog_buf.size(); k++)
         send_item(KIND_LOAD, k, prog_buf[k], $urandom_range(0, 255));
   endtask

   task automatic restart_run();
      send_item(KIND_RESTART, $urandom_range(0, 4095), $urandom_range(0, 7),
                $urandom_range(0, 255));
   endtask

   task automatic run_directed(input int len, input int steps);
      set_length(len);
      load_program();
      restart_run();
      repeat (steps) send_item(KIND_STEP, $urandom_range(0, 4095), $urandom_range(0, 7), 8'hFF);
   endtask

   // balanced bracket nesting when well_formed; noise programs are fully random
   task automatic compose_program(input int n, input logic well_formed);
      int              k;
      int              depth;
      int              r;
      int              left;
      logic [OP_W-1:0] op;
      prog_buf.delete();
      depth = 0;
      for (k = 0; k < n; k++) begin
         left = n - k;
         r    = $urandom_range(0, 99);
         if (!well_formed) op = OP_W'($urandom_range(OP_PTR_INC, OP_CLOSE));
         else if (depth > 0 && left <= depth) op = OP_CLOSE;
         else if (r < 15 && left > depth + 1) op = OP_OPEN;
         else if (r < 30 && depth > 0) op = OP_CLOSE;
         else op = OP_W'($urandom_range(OP_PTR_INC, OP_IN));
         if (op == OP_OPEN) depth++;
         else if (op == OP_CLOSE && depth > 0) depth--;
         prog_buf.push_back(op);
      end
   endtask

   initial begin
      int   addr;
      int   len;
      int   n;
      int   steps;
      int   pick;
      logic first;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_LOAD;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty program, ignored kind, then fill the region that runs may read
      set_length(0);
      send_item(KIND_STEP, 0, 0, 0);
      send_item(KIND_UNUSED, '1, '1, '1);
      for (addr = 0; addr < FILL_DEPTH; addr++)
         send_item(KIND_LOAD, addr, $urandom_range(0, 7), $urandom_range(0, 255));

      // every opcode, loop back, input 255 then wrap to 0
      prog_buf.delete();
      prog_buf.push_back(OP_CELL_INC); prog_buf.push_back(OP_CELL_INC);
      prog_buf.push_back(OP_OPEN);     prog_buf.push_back(OP_PTR_INC);
      prog_buf.push_back(OP_CELL_INC); prog_buf.push_back(OP_PTR_DEC);
      prog_buf.push_back(OP_CELL_DEC); prog_buf.push_back(OP_CLOSE);
      prog_buf.push_back(OP_PTR_INC);  prog_buf.push_back(OP_OUT);
      prog_buf.push_back(OP_IN);       prog_buf.push_back(OP_CELL_INC);
      prog_buf.push_back(OP_OUT);
      run_directed(prog_buf.size(), 20);

      // nested forward skip, pointer and cell wrap below zero, unmatched close
      prog_buf.delete();
      prog_buf.push_back(OP_OPEN);     prog_buf.push_back(OP_CELL_INC);
      prog_buf.push_back(OP_OPEN);     prog_buf.push_back(OP_CLOSE);
      prog_buf.push_back(OP_CLOSE);    prog_buf.push_back(OP_PTR_DEC);
      prog_buf.push_back(OP_CELL_DEC); prog_buf.push_back(OP_OUT);
      prog_buf.push_back(OP_CLOSE);
      run_directed(prog_buf.size(), 8);

      // unmatched open on a zero cell
      prog_buf.delete();
      prog_buf.push_back(OP_OPEN);     prog_buf.push_back(OP_OUT);
      run_directed(prog_buf.size(), 2);

      // length above depth, and exactly depth; no brackets so only loaded entries are read
      prog_buf.delete();
      prog_buf.push_back(OP_OUT);      prog_buf.push_back(OP_CELL_INC);
      prog_buf.push_back(OP_OUT);
      run_directed(LEN_MAX, 3);
      run_directed(PROG_DEPTH, 3);

      first = 1'b1;
      while (sent_count < TOTAL_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         if (pick < 80) len = $urandom_range(1, 32);
         else if (pick < 92) len = $urandom_range(33, FILL_DEPTH);
         else len = ($urandom_range(0, 1) == 0) ? 0 : FILL_DEPTH;
         if (first || $urandom_range(0, 4) != 0) set_length(len);
         n = (len < MAX_PROG) ? len : MAX_PROG;
         compose_program(n, $urandom_range(0, 4) != 0);
         load_program();
         if ($urandom_range(0, 9) < 7) restart_run();
         steps = $urandom_range(4, 2 * n + 8);
         if (steps > 60) steps = 60;
         if (first) begin
            hold_req = 1'b1;
            if (steps < 24) steps = 24;
            first = 1'b0;
         end
         repeat (steps) begin
            pick = $urandom_range(0, 29);
            if (pick == 0)
               send_item(KIND_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 7),
                         $urandom_range(0, 255));
            else if (pick == 1)
               send_item(KIND_LOAD, $urandom_range(0, 4095), $urandom_range(0, 7),
                         $urandom_range(0, 255));
            else
               send_item(KIND_STEP, $urandom_range(0, 4095), $urandom_range(0, 7),
                         $urandom_range(0, 255));
         end
      end
      burst = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("tb_bracket_loop_byte_tape_machine passed");
      else
         $display("tb_bracket_loop_byte_tape_machine failed");
      $finish;
   end

endmodule
